/* design/generational_slot_pool_core_macros.svh */
// Assertion macros for the generational slot pool core.
// Used by the top level; no other dependencies.
`ifndef GENERATIONAL_SLOT_POOL_CORE_MACROS_SVH
`define GENERATIONAL_SLOT_POOL_CORE_MACROS_SVH
`ifndef SYNTH
`define GSP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define GSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define GSP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define GSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* design/gsp_pkg.sv */
// Shared constants, codes and control structs of the generational slot pool.
// No dependencies.
package gsp_pkg;

   localparam int NUM_IDS   = 255;
   localparam int SLOT_BITS = 8;
   localparam int GEN_BITS  = 24;

   localparam int CMD_W    = 2;
   localparam int SLOT_W   = 8;
   localparam int ID_W     = 32;
   localparam int STATUS_W = 2;

   localparam int TOP_W     = $clog2(NUM_IDS + 1);
   localparam int STACK_AW  = $clog2(NUM_IDS);
   localparam int GEN_DEPTH = NUM_IDS + 1;
   localparam int GEN_AW    = $clog2(GEN_DEPTH);

   typedef enum logic [CMD_W-1:0] {
      CMD_ACQUIRE    = 2'd0,
      CMD_RELEASE    = 2'd1,
      CMD_GEN_ID     = 2'd2,
      CMD_ID_TO_SLOT = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_BAD   = 2'd2
   } status_type;

   typedef struct packed {
      logic              push;
      logic              pop;
      logic [SLOT_W-1:0] slot;
   } stk_ctl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } stk_flags_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
   } gen_rd_type;

endpackage

/* design/gsp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/gsp_stack.sv */
// Free-slot LIFO: stack pointer, per-entry written bits and stack RAM.
// Depends on gsp_pkg and gsp_ram.
module gsp_stack (
   input  logic                  clock,
   input  logic                  reset,
   input  gsp_pkg::stk_ctl_type  ctl,
   output gsp_pkg::stk_flags_type flags,
   output logic [gsp_pkg::SLOT_W-1:0] pop_slot
);
   import gsp_pkg::*;

   logic [TOP_W-1:0]    top_ff, top_in;
   logic [NUM_IDS-1:0]  vld_ff;
   logic [TOP_W-1:0]    top_dec;
   logic [STACK_AW-1:0] pop_idx, push_idx;
   logic                pop_vld_ff;
   logic [SLOT_W-1:0]   pop_dflt_ff;
   logic [SLOT_W-1:0]   ram_q;

   assign top_dec  = top_ff - TOP_W'(1);
   assign pop_idx  = top_dec[STACK_AW-1:0];
   assign push_idx = top_ff[STACK_AW-1:0];

   always_comb begin
      top_in = top_ff;
      if (ctl.pop) begin
         top_in = top_dec;
      end else if (ctl.push) begin
         top_in = top_ff + TOP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= TOP_W'(NUM_IDS);
         vld_ff <= '0;
      end else begin
         top_ff <= top_in;
         if (ctl.push) begin
            vld_ff[push_idx] <= 1'b1;
         end
      end
   end

   // unwritten entry k reads as its reset content NUM_IDS - k
   always_ff @(posedge clock) begin
      if (ctl.pop) begin
         pop_vld_ff  <= vld_ff[pop_idx];
         pop_dflt_ff <= SLOT_W'(TOP_W'(NUM_IDS) - top_dec);
      end
   end

   gsp_ram #(
      .WIDTH(SLOT_W),
      .DEPTH(NUM_IDS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ctl.push),
      .wr_addr(push_idx),
      .wr_data(ctl.slot),
      .rd_en  (ctl.pop),
      .rd_addr(pop_idx),
      .rd_data(ram_q)
   );

   assign pop_slot    = pop_vld_ff ? ram_q : pop_dflt_ff;
   assign flags.empty = (top_ff == '0);
   assign flags.full  = (top_ff >= TOP_W'(NUM_IDS));

endmodule

/* design/gsp_gen.sv */
// Per-slot generation counters: RAM, written bits and write-to-read forwarding.
// Depends on gsp_pkg and gsp_ram.
module gsp_gen (
   input  logic                         clock,
   input  logic                         reset,
   input  gsp_pkg::gen_rd_type          rd,
   input  logic                         wr_en,
   output logic [gsp_pkg::GEN_BITS-1:0] gen_next
);
   import gsp_pkg::*;

   logic [GEN_AW-1:0]    rd_addr;
   logic [GEN_AW-1:0]    addr_ff;
   logic [GEN_DEPTH-1:0] vld_ff;
   logic                 rd_vld_ff;
   logic                 hit_ff, hit_in;
   logic [GEN_BITS-1:0]  fwd_ff;
   logic [GEN_BITS-1:0]  ram_q, gen_old;

   assign rd_addr = rd.slot[GEN_AW-1:0];

   // counter committed in the same cycle as the read: RAM still holds the old value
   assign hit_in = wr_en && rd.en && (rd_addr == addr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[addr_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         addr_ff   <= rd_addr;
         rd_vld_ff <= vld_ff[rd_addr];
         hit_ff    <= hit_in;
         fwd_ff    <= gen_next;
      end
   end

   gsp_ram #(
      .WIDTH(GEN_BITS),
      .DEPTH(GEN_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(addr_ff),
      .wr_data(gen_next),
      .rd_en  (rd.en),
      .rd_addr(rd_addr),
      .rd_data(ram_q)
   );

   assign gen_old  = hit_ff ? fwd_ff : (rd_vld_ff ? ram_q : '0);
   assign gen_next = gen_old + GEN_BITS'(1);

endmodule

/* design/generational_slot_pool_core.sv */
// Top level of the generational slot pool: request decode, pipeline and result register.
// Depends on gsp_pkg, gsp_stack, gsp_gen and generational_slot_pool_core_macros.svh.
//
// Usage:
//  - Request channel (req_valid/req_ready) carries one command per transaction:
//    acquire, release, generate id, id to slot, with req_slot and req_id.
//  - Response channel (rsp_valid/rsp_ready) returns exactly one transaction per
//    request, in order: rsp_slot_out, rsp_id_out, rsp_status.
//  - An accepted request is held in the decode stage, then in the output register.
//  - Throughput: one request per cycle while rsp_ready is high, set by the single
//    read-modify-write of stack pointer and generation counter (one RAM port each).
//  - Stall: two transactions can be in flight (decode stage and output register);
//    req_ready drops only while both are full and rsp_ready is low.
//  - Reset (synchronous): the free stack reads as full with slot 1 on top and all
//    generation counters read as zero at once; no clearing pass, so requests are
//    taken in the first cycle after reset.
`include "generational_slot_pool_core_macros.svh"
module generational_slot_pool_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [gsp_pkg::CMD_W-1:0]    req_cmd,
   input  logic [gsp_pkg::SLOT_W-1:0]   req_slot,
   input  logic [gsp_pkg::ID_W-1:0]     req_id,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [gsp_pkg::SLOT_W-1:0]   rsp_slot_out,
   output logic [gsp_pkg::ID_W-1:0]     rsp_id_out,
   output logic [gsp_pkg::STATUS_W-1:0] rsp_status
);
   import gsp_pkg::*;

   // handshake
   logic accept, advance;

   // request decode
   cmd_type       cmd;
   logic          slot_ok;
   status_type    status_in;
   stk_ctl_type   stk_ctl;
   stk_flags_type stk_flags;
   gen_rd_type    gen_rd;
   logic          gen_wr;

   // decode stage
   logic              s1_valid_ff, s1_valid_in;
   cmd_type           s1_cmd_ff;
   logic [SLOT_W-1:0] s1_slot_ff;
   logic [SLOT_W-1:0] s1_id_slot_ff;
   status_type        s1_status_ff;

   // unit results for the decode stage
   logic [SLOT_W-1:0]   pop_slot;
   logic [GEN_BITS-1:0] gen_next;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] rsp_slot_out_ff, rsp_slot_out_in;
   logic [ID_W-1:0]   rsp_id_out_ff, rsp_id_out_in;
   status_type        rsp_status_ff;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   assign cmd     = cmd_type'(req_cmd);
   assign slot_ok = (req_slot != '0) && (req_slot <= SLOT_W'(NUM_IDS));

   // all error checks resolve at accept; the stack pointer moves here too
   always_comb begin
      case (cmd)
         CMD_ACQUIRE: begin
            status_in = stk_flags.empty ? STATUS_EMPTY : STATUS_OK;
         end
         CMD_RELEASE: begin
            status_in = (!slot_ok || stk_flags.full) ? STATUS_BAD : STATUS_OK;
         end
         CMD_GEN_ID: begin
            status_in = slot_ok ? STATUS_OK : STATUS_BAD;
         end
         CMD_ID_TO_SLOT: begin
            status_in = STATUS_OK;
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
   end

   assign stk_ctl.pop  = accept && (cmd == CMD_ACQUIRE) && !stk_flags.empty;
   assign stk_ctl.push = accept && (cmd == CMD_RELEASE) && slot_ok && !stk_flags.full;
   assign stk_ctl.slot = req_slot;

   assign gen_rd.en   = accept && (cmd == CMD_GEN_ID) && slot_ok;
   assign gen_rd.slot = req_slot;

   // counter write-back happens as the transaction leaves the decode stage
   assign gen_wr = advance && (s1_cmd_ff == CMD_GEN_ID) && (s1_status_ff == STATUS_OK);

   gsp_stack u_stack (
      .clock   (clock),
      .reset   (reset),
      .ctl     (stk_ctl),
      .flags   (stk_flags),
      .pop_slot(pop_slot)
   );

   gsp_gen u_gen (
      .clock   (clock),
      .reset   (reset),
      .rd      (gen_rd),
      .wr_en   (gen_wr),
      .gen_next(gen_next)
   );

   // response formatting
   always_comb begin
      rsp_slot_out_in = '0;
      rsp_id_out_in   = '0;
      case (s1_cmd_ff)
         CMD_ACQUIRE: begin
            if (s1_status_ff == STATUS_OK) begin
               rsp_slot_out_in = pop_slot;
            end
         end
         CMD_GEN_ID: begin
            if (s1_status_ff == STATUS_OK) begin
               rsp_id_out_in = ID_W'({gen_next, s1_slot_ff[SLOT_BITS-1:0]});
            end
         end
         CMD_ID_TO_SLOT: begin
            rsp_slot_out_in = s1_id_slot_ff;
         end
         default: begin
            rsp_slot_out_in = '0;
         end
      endcase
   end

   assign s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff     <= cmd;
         s1_slot_ff    <= req_slot;
         s1_id_slot_ff <= SLOT_W'(req_id[SLOT_BITS-1:0]);
         s1_status_ff  <= status_in;
      end
      if (advance) begin
         rsp_slot_out_ff <= rsp_slot_out_in;
         rsp_id_out_ff   <= rsp_id_out_in;
         rsp_status_ff   <= s1_status_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_slot_out = rsp_slot_out_ff;
   assign rsp_id_out   = rsp_id_out_ff;
   assign rsp_status   = rsp_status_ff;

   // backpressure only when both stages hold a transaction and the receiver stalls
   `GSP_ASSERT_IMPLY(a_ready_only_when_full, clock, reset, !req_ready,
      s1_valid_ff && rsp_valid_ff && !rsp_ready, "request stalled with room in pipe")
   // failed transactions never carry a handle
   `GSP_ASSERT_IMPLY(a_err_no_handle, clock, reset,
      rsp_valid_ff && (rsp_status_ff != STATUS_OK), rsp_id_out_ff == '0,
      "handle returned on error")
   // acquire on an empty stack reports empty in the decode stage
   `GSP_ASSERT_NEXT(a_empty_status, clock, reset,
      accept && (cmd == CMD_ACQUIRE) && stk_flags.empty,
      s1_status_ff == STATUS_EMPTY, "empty acquire not flagged")
   // a generated handle carries its own slot in the low bits
   `GSP_ASSERT_NEXT(a_handle_slot, clock, reset, gen_wr,
      rsp_id_out_ff[SLOT_BITS-1:0] == $past(s1_slot_ff[SLOT_BITS-1:0]),
      "handle slot bits mismatch")

endmodule
